// ----- rtl/core/address_resolution_cache_defines.svh -----
// ----------------------------------------------------------------------------
// Address resolution cache: assertion macros
// Shared concurrent assertion forms for the cache checker.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_RESOLUTION_CACHE_DEFINES_SVH
`define ADDRESS_RESOLUTION_CACHE_DEFINES_SVH

// Clocked assertion with reset disable and a fixed message.
`define ARC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("address resolution cache assertion failed");

// Clocked assertion with reset disable and a caller message.
`define ARC_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

`endif

// ----- rtl/core/arc_pkg.sv -----
// ----------------------------------------------------------------------------
// Address resolution cache package
// Types and constants shared by the cache cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package arc_pkg;

  localparam int unsigned DefaultEntries = 16;
  localparam int unsigned ProtoW         = 32;
  localparam int unsigned HwW            = 48;
  localparam int unsigned SlotW          = 4;
  localparam logic [7:0]  LoopbackOctet  = 8'h7F;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_INSERT = 1'b1
  } op_e;

  // Query traveling down the row of cells, with its partial result
  typedef struct packed {
    op_e               op;
    logic [ProtoW-1:0] pa;
    logic [HwW-1:0]    ha;
    logic              done;
    logic              found;
    logic [HwW-1:0]    res;
    logic [SlotW-1:0]  slot;
  } query_t;

  // Fallback write into the first cell when no slot qualified
  typedef struct packed {
    logic              we;
    logic [ProtoW-1:0] pa;
    logic [HwW-1:0]    ha;
  } fill_t;

endpackage

`default_nettype wire

// ----- rtl/core/address_resolution_cache.sv -----
// ----------------------------------------------------------------------------
// Address resolution cache
// Table of protocol-to-hardware address mappings built as a row of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one item: an operation
//   (lookup or insert), a 32-bit protocol address and a 48-bit hardware
//   address. Output channel (out_valid_o / out_ready_i) returns one item per
//   input: found flag, resolved hardware address and the slot used.
//   An accepted item is registered, then walks the row of Entries cells, one
//   cell per cycle; each cell compares against its own entry, and the first
//   qualifying cell claims the item (and writes itself on insert). Loopback
//   lookups are resolved on entry and pass through untouched.
//   out_valid_o rises once the item has passed the entry stage, every cell
//   and the result register. in_ready_o stays low while the item sits in the
//   entry stage or the row, so a new item is not accepted until the previous
//   one has left the cell row. An insert that finds no slot rewrites slot 0
//   as it leaves the row. Reset clears all valid marks and empties the row
//   and output register. A stalled receiver holds the result register and
//   freezes the whole row; a stall while an item walks delays its result.
// ----------------------------------------------------------------------------
`default_nettype none

module address_resolution_cache import arc_pkg::*; #(
  parameter int unsigned Entries = DefaultEntries
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              operation_i,
  input  wire logic [ProtoW-1:0] protocol_address_i,
  input  wire logic [HwW-1:0]    hardware_address_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   found_o,
  output logic [HwW-1:0]         resolved_address_o,
  output logic [SlotW-1:0]       slot_used_o
);

  // entry stage, ahead of the first cell
  logic   s0_valid_q;
  query_t s0_q;
  query_t s0_d;

  // row of cells
  logic   [Entries-1:0] cell_valid;
  query_t               cell_q [Entries];
  fill_t                fill;

  // result register
  logic              out_valid_q;
  logic              found_q;
  logic [HwW-1:0]    res_q;
  logic [SlotW-1:0]  slot_q;

  logic   in_acc;
  logic   adv;
  logic   busy;
  logic   last_valid;
  query_t last_q;
  logic   loopback;

  assign busy       = s0_valid_q || (|cell_valid);
  assign in_ready_o = !busy;
  assign in_acc     = in_valid_i && in_ready_o;

  assign last_valid = cell_valid[Entries-1];
  assign last_q     = cell_q[Entries-1];

  // freeze the row while a result waits to be taken
  assign adv = !(out_valid_q && !out_ready_i);

  // loopback lookups are answered here and skip the table
  assign loopback = (op_e'(operation_i) == OP_LOOKUP) &&
                    (protocol_address_i[7:0] == LoopbackOctet);

  always_comb begin
    s0_d.op    = op_e'(operation_i);
    s0_d.pa    = protocol_address_i;
    s0_d.ha    = hardware_address_i;
    s0_d.done  = loopback;
    s0_d.found = loopback;
    s0_d.res   = '0;
    s0_d.slot  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else if (in_acc) begin
      s0_valid_q <= 1'b1;
    end else if (adv) begin
      s0_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s0_q <= s0_d;
    end
  end

  // no qualifying slot: overwrite slot 0 as the insert leaves the row
  assign fill.we = last_valid && adv && (last_q.op == OP_INSERT) && !last_q.done;
  assign fill.pa = last_q.pa;
  assign fill.ha = last_q.ha;

  for (genvar i = 0; i < Entries; i++) begin : g_cell
    logic   prev_valid;
    query_t prev_q;
    fill_t  cell_fill;

    if (i == 0) begin : g_first
      assign prev_valid = s0_valid_q;
      assign prev_q     = s0_q;
      assign cell_fill  = fill;
    end else begin : g_rest
      assign prev_valid = cell_valid[i-1];
      assign prev_q     = cell_q[i-1];
      assign cell_fill  = '0;
    end

    arc_cell #(
      .Index (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .adv_i       (adv),
      .in_valid_i  (prev_valid),
      .in_q_i      (prev_q),
      .fill_i      (cell_fill),
      .out_valid_o (cell_valid[i]),
      .out_q_o     (cell_q[i])
    );
  end

  // result register: load when the item leaves the row, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_valid && adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_valid && adv) begin
      found_q <= last_q.found || (last_q.op == OP_INSERT);
      res_q   <= last_q.res;
      slot_q  <= last_q.slot;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign found_o            = found_q;
  assign resolved_address_o = res_q;
  assign slot_used_o        = slot_q;

endmodule

`default_nettype wire

// ----- rtl/core/arc_cell.sv -----
// ----------------------------------------------------------------------------
// Address resolution cache cell
// One table entry plus one stage of the query row.
// ----------------------------------------------------------------------------
`default_nettype none

module arc_cell import arc_pkg::*; #(
  parameter int unsigned Index = 0
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   adv_i,
  input  wire logic   in_valid_i,
  input  wire query_t in_q_i,
  input  wire fill_t  fill_i,
  output logic        out_valid_o,
  output query_t      out_q_o
);

  localparam logic [SlotW-1:0] SlotIdx = SlotW'(Index);

  logic              valid_q;
  logic [ProtoW-1:0] pa_q;
  logic [HwW-1:0]    ha_q;
  logic              out_valid_q;
  query_t            out_q_q;
  query_t            q_d;
  logic              pa_match;
  logic              is_insert;
  logic              take;
  logic              we;

  assign pa_match  = (pa_q == in_q_i.pa);
  assign is_insert = (in_q_i.op == OP_INSERT);
  assign take      = in_valid_i && !in_q_i.done &&
                     (is_insert ? (!valid_q || pa_match) : (valid_q && pa_match));
  assign we        = (take && is_insert && adv_i) || fill_i.we;

  // claim the query: first qualifying cell wins
  always_comb begin
    q_d = in_q_i;
    if (take) begin
      q_d.done  = 1'b1;
      q_d.found = 1'b1;
      q_d.slot  = SlotIdx;
      q_d.res   = is_insert ? '0 : ha_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (we) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      pa_q <= fill_i.we ? fill_i.pa : in_q_i.pa;
      ha_q <= fill_i.we ? fill_i.ha : in_q_i.ha;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      out_q_q <= q_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_q_o     = out_q_q;

endmodule

`default_nettype wire

// ----- rtl/core/arc_checker.sv -----
// ----------------------------------------------------------------------------
// Address resolution cache checker
// Port-level properties of the cache, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "address_resolution_cache_defines.svh"

module arc_checker import arc_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid_i,
  input wire logic              in_ready_o,
  input wire logic              out_valid_o,
  input wire logic              out_ready_i,
  input wire logic              found_o,
  input wire logic [HwW-1:0]    resolved_address_o,
  input wire logic [SlotW-1:0]  slot_used_o
);

  // one item in flight: ready drops right after an accept
  `ARC_ASSERT(a_one_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o)

  // a miss reports neither address nor slot
  `ARC_ASSERT_MSG(a_miss_clean,
    (out_valid_o && !found_o) |-> (resolved_address_o == '0 && slot_used_o == '0),
    "lookup miss carries address or slot")

  // result holds while stalled
  `ARC_ASSERT(a_out_hold, (out_valid_o && !out_ready_i) |=> out_valid_o)

  `ARC_ASSERT_MSG(a_out_stable,
    (out_valid_o && !out_ready_i) |=>
      ($stable(found_o) && $stable(resolved_address_o) && $stable(slot_used_o)),
    "result changed while stalled")

endmodule

bind address_resolution_cache arc_checker u_arc_checker (.*);

`default_nettype wire

// ----- tb/address_resolution_cache_checker.sv -----
// ----------------------------------------------------------------------------
// Address resolution cache checker
// Watches both channels of the cache, keeps its own copy of the mapping
// table, works out the result of every accepted item and compares each
// returned item field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module address_resolution_cache_checker import arc_pkg::*; #(
  parameter int unsigned Entries = DefaultEntries
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic              operation_i,
  input  logic [ProtoW-1:0] protocol_address_i,
  input  logic [HwW-1:0]    hardware_address_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              found_i,
  input  logic [HwW-1:0]    resolved_address_i,
  input  logic [SlotW-1:0]  slot_used_i,
  output int unsigned       failures_o,
  output int unsigned       pending_o
);

  typedef struct packed {
    logic             found;
    logic [HwW-1:0]   resolved;
    logic [SlotW-1:0] slot;
  } resolution_t;

  logic              valid_tbl [Entries];
  logic [ProtoW-1:0] proto_tbl [Entries];
  logic [HwW-1:0]    hw_tbl    [Entries];

  resolution_t resolution_q [$];
  int unsigned mismatches = 0;

  // Predict one item and update the shadow table on insert
  function automatic resolution_t resolve_item(input op_e op, input logic [ProtoW-1:0] pa,
                                               input logic [HwW-1:0] ha);
    resolution_t res;
    int unsigned target;
    bit          hit;
    res    = '0;
    target = 0;
    hit    = 1'b0;
    if (op == OP_INSERT) begin
      // first slot with the same address or without a valid mark; slot 0 if none
      for (int i = 0; i < Entries; i++) begin
        if (!hit && (proto_tbl[i] == pa || !valid_tbl[i])) begin
          target = i;
          hit    = 1'b1;
        end
      end
      proto_tbl[target] = pa;
      hw_tbl[target]    = ha;
      valid_tbl[target] = 1'b1;
      res.found = 1'b1;
      res.slot  = SlotW'(target);
    end else if (pa[7:0] == LoopbackOctet) begin
      res.found = 1'b1;
    end else begin
      for (int i = 0; i < Entries; i++) begin
        if (!hit && valid_tbl[i] && proto_tbl[i] == pa) begin
          hit          = 1'b1;
          res.found    = 1'b1;
          res.resolved = hw_tbl[i];
          res.slot     = SlotW'(i);
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    resolution_t seen;
    resolution_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Entries; i++) begin
        valid_tbl[i] = 1'b0;
        proto_tbl[i] = '0;
        hw_tbl[i]    = '0;
      end
      resolution_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen = '{found_i, resolved_address_i, slot_used_i};
        if (resolution_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual found %0b address %h slot %0d",
                   $time, seen.found, seen.resolved, seen.slot);
          mismatches++;
        end else begin
          want = resolution_q.pop_front();
          if (seen.found !== want.found) begin
            $display("%0t: found mismatch: expected %0b, actual %0b",
                     $time, want.found, seen.found);
            mismatches++;
          end
          if (seen.resolved !== want.resolved) begin
            $display("%0t: resolved address mismatch: expected %h, actual %h",
                     $time, want.resolved, seen.resolved);
            mismatches++;
          end
          if (seen.slot !== want.slot) begin
            $display("%0t: slot mismatch: expected %0d, actual %0d",
                     $time, want.slot, seen.slot);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        resolution_q.push_back(resolve_item(op_e'(operation_i), protocol_address_i,
                                            hardware_address_i));
      end
    end
    failures_o <= mismatches;
    pending_o  <= resolution_q.size();
  end

endmodule

// ----- tb/address_resolution_cache_tb.sv -----
// ----------------------------------------------------------------------------
// Address resolution cache testbench
// Drives lookups and inserts into the cache with random idling on both
// channels; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module address_resolution_cache_tb import arc_pkg::*;;

  localparam int unsigned RandomItems = 1450;
  localparam int unsigned KnownDepth  = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Sender side
  logic              in_valid         = 1'b0;
  logic              in_ready;
  op_e               operation        = OP_LOOKUP;
  logic [ProtoW-1:0] protocol_address = '0;
  logic [HwW-1:0]    hardware_address = '0;

  // Receiver side
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              found;
  logic [HwW-1:0]    resolved_address;
  logic [SlotW-1:0]  slot_used;

  // No idling on either side while calm is set
  logic calm = 1'b0;

  int unsigned failures;
  int unsigned pending;

  // Recently inserted protocol addresses: drive hits, refreshes and stale misses
  logic [ProtoW-1:0] known_pa [KnownDepth];
  int unsigned       known_wr = 0;

  always #5 clk_i = ~clk_i;

  address_resolution_cache uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .operation_i        (operation),
    .protocol_address_i (protocol_address),
    .hardware_address_i (hardware_address),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .found_o            (found),
    .resolved_address_o (resolved_address),
    .slot_used_o        (slot_used)
  );

  address_resolution_cache_checker resolution_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_i         (in_ready),
    .operation_i        (operation),
    .protocol_address_i (protocol_address),
    .hardware_address_i (hardware_address),
    .out_valid_i        (out_valid),
    .out_ready_i        (out_ready),
    .found_i            (found),
    .resolved_address_i (resolved_address),
    .slot_used_i        (slot_used),
    .failures_o         (failures),
    .pending_o          (pending)
  );

  // Stall the receiver on about 15 percent of cycles, except in the calm stretch
  always @(posedge clk_i) begin
    out_ready <= calm || ($urandom_range(99) >= 15);
  end

  // Release reset once
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard stop in case the block hangs
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

  // Random 48-bit hardware address
  function automatic logic [HwW-1:0] random_hw();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return wide[HwW-1:0];
  endfunction

  // Random protocol address, loopback octet now and then
  function automatic logic [ProtoW-1:0] random_pa();
    logic [ProtoW-1:0] pa;
    pa = $urandom;
    if ($urandom_range(4) == 0) pa[7:0] = LoopbackOctet;
    return pa;
  endfunction

  // Present one item and hold it until accepted. Called at a clock edge.
  task automatic send_item(input op_e op, input logic [ProtoW-1:0] pa,
                           input logic [HwW-1:0] ha);
    // Idle the sender for a random stretch, so gaps hit every phase of the walk
    if (!calm && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
    in_valid         <= 1'b1;
    operation        <= op;
    protocol_address <= pa;
    hardware_address <= ha;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    if (op == OP_INSERT) begin
      known_pa[known_wr] = pa;
      known_wr = (known_wr + 1) % KnownDepth;
    end
  endtask

  // Drop valid and hold off until every predicted result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin
    int unsigned roll;
    for (int i = 0; i < KnownDepth; i++) known_pa[i] = '0;
    wait (rst_ni);
    @(posedge clk_i);

    // Lookups against an empty table: a plain miss and a loopback
    send_item(OP_LOOKUP, 32'h0100000A, '0);
    send_item(OP_LOOKUP, 32'hFFFFFF7F, 48'hFFFFFFFFFFFF);
    // Field extremes on insert
    send_item(OP_INSERT, 32'h00000000, 48'h000000000000);
    send_item(OP_INSERT, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF);
    // Insert a loopback address: stored like any other
    send_item(OP_INSERT, 32'h0100007F, 48'h0123456789AB);
    // Loopback lookup bypasses the table even though the address is stored
    send_item(OP_LOOKUP, 32'h0100007F, '0);
    // Hits, including one whose stored hardware address is zero
    send_item(OP_LOOKUP, 32'h00000000, 48'hFFFFFFFFFFFF);
    send_item(OP_LOOKUP, 32'hFFFFFFFF, '0);
    // Refresh an existing mapping, then read it back
    send_item(OP_INSERT, 32'hFFFFFFFF, 48'hA5A5A5A5A5A5);
    send_item(OP_LOOKUP, 32'hFFFFFFFF, '0);
    // Address just beside the loopback octet is a normal miss
    send_item(OP_LOOKUP, 32'hFFFFFF7E, '0);
    // Fill every remaining slot
    for (int i = 3; i < DefaultEntries; i++) begin
      send_item(OP_INSERT, 32'h0000A8C0 | (i << 24), random_hw());
    end
    // Full table without a match overwrites slot 0, evicting address zero
    send_item(OP_INSERT, 32'h5A5A5A5A, 48'h800000000001);
    send_item(OP_LOOKUP, 32'h00000000, '0);
    send_item(OP_LOOKUP, 32'h5A5A5A5A, '0);
    drain();

    for (int n = 0; n < RandomItems; n++) begin
      calm <= (n >= 500 && n < 800);
      // Let the block run dry once mid-stream
      if (n == 300) drain();
      roll = $urandom_range(99);
      if (roll < 30) begin
        send_item(OP_INSERT, known_pa[$urandom_range(KnownDepth - 1)], random_hw());
      end else if (roll < 45) begin
        send_item(OP_INSERT, random_pa(), random_hw());
      end else if (roll < 80) begin
        send_item(OP_LOOKUP, known_pa[$urandom_range(KnownDepth - 1)], random_hw());
      end else if (roll < 88) begin
        send_item(OP_LOOKUP, {24'($urandom), LoopbackOctet}, random_hw());
      end else begin
        send_item(OP_LOOKUP, random_pa(), random_hw());
      end
    end

    // Wait out every outstanding result, then a margin past the walk latency
    drain();
    repeat (40) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
